/* hw/rtl/imf_pkg.sv */
// ----------------------------------------------------------------------------
// imf_pkg - shared definitions for the Ising Metropolis flip engine
// Operation codes, register indexes, field widths and default lattice size.
// ----------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

	localparam int SIDE_DEFAULT = 128;

	localparam int OP_W      = 2;
	localparam int COORD_W   = 7;
	localparam int DRAW_W    = 16;
	localparam int LOCAL_W   = 4;
	localparam int MAG_W     = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int ZERO_W    = 32;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_FLIP = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_UP_TABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_TABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_TABLE = 2'd2;

	// Threshold code that accepts unconditionally
	localparam logic [DRAW_W-1:0] THRESH_ALWAYS = 16'hFFFF;

	localparam logic [CFG_W-1:0]  UP_TABLE_RESET   = '0;
	localparam logic [CFG_W-1:0]  DOWN_TABLE_RESET = '0;
	localparam logic [ZERO_W-1:0] ZERO_TABLE_RESET = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

/* hw/rtl/ising_metropolis_flip.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_flip - Metropolis spin-flip engine, 2-D Ising lattice
// SIDE x SIDE one-bit spins with open edges, row-organized in one memory,
// plus a running magnetization. Loads, reads or attempts a flip at a site.
// ----------------------------------------------------------------------------
//
//  channel   signals                                       handshake
//  -------   -------------------------------------------   --------------------------
//  command   op, row, col, spin_in, random_draw            start && !busy
//  result    spin_out, flipped, local_field, magnetization done, one cycle, no stall
//  config    cfg_index, cfg_data                           cfg_we, single cycle write
//
//  Sequence: an in-range command keeps busy high through three reads of the
//  single lattice read port (own row, row above, row below), then an evaluate
//  cycle that decides, writes the spin back and registers the result. The
//  result beat shows on done in the cycle after that, when busy is already low.
//  A site outside the lattice returns its beat in the next cycle.
//  Reset: a clearing pass writes one lattice row per cycle, all SIDE rows, with
//  busy high; configuration writes are taken meanwhile.
//  Stalls: the receiver cannot stall; each beat lasts exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_flip #(
	parameter int SIDE = imf_pkg::SIDE_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [imf_pkg::OP_W-1:0]          op,
	input  wire logic [imf_pkg::COORD_W-1:0]       row,
	input  wire logic [imf_pkg::COORD_W-1:0]       col,
	input  wire logic                              spin_in,
	input  wire logic [imf_pkg::DRAW_W-1:0]        random_draw,
	output logic                                   done,
	output logic                                   spin_out,
	output logic                                   flipped,
	output logic signed [imf_pkg::LOCAL_W-1:0]     local_field,
	output logic signed [imf_pkg::MAG_W-1:0]       magnetization,
	input  wire logic                              cfg_we,
	input  wire logic [imf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [imf_pkg::CFG_W-1:0]         cfg_data
);
	import imf_pkg::*;

	localparam int AW    = (SIDE > 1) ? $clog2(SIDE) : 1;
	localparam int CMP_W = ($clog2(SIDE + 1) > COORD_W) ? $clog2(SIDE + 1) : COORD_W;
	localparam int CELLS = SIDE * SIDE;
	localparam int SW    = $clog2(CELLS + 1) + 1;

	localparam logic [AW-1:0]        LAST_IDX  = AW'(SIDE - 1);
	localparam logic [CMP_W-1:0]     SIDE_CMP  = CMP_W'(SIDE);
	localparam logic signed [SW-1:0] SUM_RESET = SW'(-CELLS);
	localparam logic signed [SW-1:0] SUM_STEP  = SW'(2);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MID   = 6'b000100,
		S_UP    = 6'b001000,
		S_DN    = 6'b010000,
		S_EVAL  = 6'b100000
	} state_t;

	function automatic logic signed [LOCAL_W-1:0] nb_term(input logic ok, input logic b);
		return ok ? (b ? 4'sd1 : -4'sd1) : 4'sd0;
	endfunction

	state_t state_q, state_d;

	logic [AW-1:0]           clr_q;
	logic [AW-1:0]           row_q, col_q;
	logic [OP_W-1:0]         op_q;
	logic                    spin_in_q;
	logic [DRAW_W-1:0]       draw_q;
	logic                    s_q, lf_q, rt_q, up_q;
	logic signed [SW-1:0]    spin_sum_q;
	logic [CFG_W-1:0]        up_tbl_q, dn_tbl_q;
	logic [ZERO_W-1:0]       zero_tbl_q;
	logic                    done_q;

	// lattice memory, one row per entry
	logic [SIDE-1:0]         mem [SIDE];
	logic [SIDE-1:0]         rd_data_q;
	logic [AW-1:0]           rd_addr;

	logic [CMP_W-1:0]        row_ext, col_ext;
	logic                    in_range, accept_cmd;
	logic                    up_ok, dn_ok, lf_ok, rt_ok;
	logic                    mid_bit, lf_bit, rt_bit;
	logic [AW-1:0]           col_m1, col_p1;
	logic signed [LOCAL_W-1:0] nsum, local_v;
	logic [1:0]              lidx;
	logic [CFG_W-1:0]        tbl;
	logic [DRAW_W-1:0]       thresh;
	logic                    accept_flip, new_spin, wr_en;

	// ---------------------------------------------------------------- command
	assign row_ext    = CMP_W'(row);
	assign col_ext    = CMP_W'(col);
	assign in_range   = (row_ext < SIDE_CMP) && (col_ext < SIDE_CMP);
	assign accept_cmd = start && !busy;
	assign busy       = (state_q != S_IDLE);

	// neighbours that exist on an open lattice
	assign up_ok = (row_q != '0);
	assign dn_ok = (row_q != LAST_IDX);
	assign lf_ok = (col_q != '0);
	assign rt_ok = (col_q != LAST_IDX);

	assign col_m1  = col_q - 1'b1;
	assign col_p1  = col_q + 1'b1;
	assign mid_bit = rd_data_q[col_q];
	assign lf_bit  = lf_ok ? rd_data_q[col_m1] : 1'b0;
	assign rt_bit  = rt_ok ? rd_data_q[col_p1] : 1'b0;

	// read address: own row, then the row above, then the row below
	always_comb begin
		unique case (state_q)
			S_UP:    rd_addr = up_ok ? row_q - 1'b1 : row_q;
			S_DN:    rd_addr = dn_ok ? row_q + 1'b1 : row_q;
			default: rd_addr = row_q;
		endcase
	end

	// ---------------------------------------------------------------- evaluate
	always_comb begin
		nsum = nb_term(up_ok, up_q) + nb_term(dn_ok, mid_bit)
		     + nb_term(lf_ok, lf_q) + nb_term(rt_ok, rt_q);
		local_v = s_q ? nsum : -nsum;
		lidx    = local_v[1:0] - 2'd1;
		tbl     = s_q ? up_tbl_q : dn_tbl_q;

		case (lidx)
			2'd0:    thresh = tbl[15:0];
			2'd1:    thresh = tbl[31:16];
			2'd2:    thresh = tbl[47:32];
			default: thresh = tbl[63:48];
		endcase
		if (local_v == 4'sd0) begin
			thresh = s_q ? zero_tbl_q[15:0] : zero_tbl_q[31:16];
		end

		// a negative local field lowers the energy: always flip
		accept_flip = local_v[LOCAL_W-1] || (thresh == THRESH_ALWAYS) ||
		              (draw_q < thresh);

		unique case (op_q)
			OP_LOAD: new_spin = spin_in_q;
			OP_FLIP: new_spin = accept_flip ? ~s_q : s_q;
			default: new_spin = s_q;
		endcase
	end

	assign wr_en = (state_q == S_EVAL) && (new_spin != s_q);

	// ---------------------------------------------------------------- memory
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[row_q][col_q] <= new_spin;
		end
		rd_data_q <= mem[rd_addr];
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == LAST_IDX) state_d = S_IDLE;
			S_IDLE:  if (accept_cmd && in_range) state_d = S_MID;
			S_MID:   state_d = S_UP;
			S_UP:    state_d = S_DN;
			S_DN:    state_d = S_EVAL;
			S_EVAL:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			spin_sum_q <= SUM_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_EVAL) || (accept_cmd && !in_range);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// step the running sum by two, up or down, for each changed spin
			if (wr_en) begin
				spin_sum_q <= new_spin ? spin_sum_q + SUM_STEP : spin_sum_q - SUM_STEP;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_tbl_q   <= UP_TABLE_RESET;
			dn_tbl_q   <= DOWN_TABLE_RESET;
			zero_tbl_q <= ZERO_TABLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UP_TABLE:   up_tbl_q   <= cfg_data;
				REG_DOWN_TABLE: dn_tbl_q   <= cfg_data;
				REG_ZERO_TABLE: zero_tbl_q <= cfg_data[ZERO_W-1:0];
				default:        ;
			endcase
		end
	end

	// command capture, neighbour capture and result registers
	always_ff @(posedge clk) begin
		if (accept_cmd) begin
			row_q     <= row_ext[AW-1:0];
			col_q     <= col_ext[AW-1:0];
			op_q      <= op;
			spin_in_q <= spin_in;
			draw_q    <= random_draw;
		end
		if (state_q == S_UP) begin
			s_q  <= mid_bit;
			lf_q <= lf_bit;
			rt_q <= rt_bit;
		end
		if (state_q == S_DN) begin
			up_q <= mid_bit;
		end
		if (state_q == S_EVAL) begin
			spin_out      <= new_spin;
			flipped       <= (op_q == OP_FLIP) && accept_flip;
			local_field   <= local_v;
			magnetization <= MAG_W'(wr_en ? (new_spin ? spin_sum_q + SUM_STEP
			                                          : spin_sum_q - SUM_STEP)
			                              : spin_sum_q);
		end else if (accept_cmd && !in_range) begin
			// site outside the lattice: report the current sum only
			spin_out      <= 1'b0;
			flipped       <= 1'b0;
			local_field   <= '0;
			magnetization <= MAG_W'(spin_sum_q);
		end
	end

	assign done = done_q;

	// ---------------------------------------------------------------- checks
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_EVAL || (start && !busy && !in_range)))
		else $error("result beat without a finished command");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result beat while the sequencer is not idle");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EVAL) |=> $stable(spin_sum_q))
		else $error("spin sum moved outside the evaluate cycle");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (busy && !done_q))
		else $error("command path open during the clearing pass");

endmodule

`default_nettype wire

/* test/ising_metropolis_flip_tb.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_flip_tb - self-checking bench for the Metropolis flip engine
// Drives load, read and flip commands into the lattice and predicts every result
// beat: spin, flip decision, local field and magnetization. The predictor keeps
// its own lattice and threshold tables. Several table settings are used, and the
// command side idles at three different rates.
// ----------------------------------------------------------------------------
module ising_metropolis_flip_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import imf_pkg::*;

	localparam int LATTICE_SIDE   = SIDE_DEFAULT;
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int WATCHDOG_LIMIT = 1000;  // outlasts the clearing pass; gaps are short
	localparam int SETTLE_CYCLES  = 8;     // result beat is registered behind busy; keep margin
	localparam int MAX_REPORTS    = 40;
	localparam int WINDOW         = 6;     // random sites cluster in a small patch
	localparam int PATCH_ITEMS    = 24;    // move the patch after this many commands
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 215;

	// op 3 has no name in the package; the block treats it as a read
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                       spin;
		logic                       flipped;
		logic signed [LOCAL_W-1:0]  local_f;
		logic signed [MAG_W-1:0]    mag;
	} flip_result_t;

	// Predictor plus scoreboard: keeps a private lattice, the running spin sum and
	// the threshold tables, and queues one expected result per accepted command.
	class lattice_scoreboard;
		bit                 lattice [LATTICE_SIDE*LATTICE_SIDE];
		int                 spin_total;
		logic [CFG_W-1:0]   up_table;
		logic [CFG_W-1:0]   down_table;
		logic [ZERO_W-1:0]  zero_table;
		flip_result_t       pending_results [$];
		int                 mismatches;
		int                 results_checked;
		int                 commands_noted;
		int                 flips_predicted;

		function new();
			spin_total = -(LATTICE_SIDE * LATTICE_SIDE);
			up_table   = UP_TABLE_RESET;
			down_table = DOWN_TABLE_RESET;
			zero_table = ZERO_TABLE_RESET;
		endfunction

		function int spin_value(int idx);
			return lattice[idx] ? 1 : -1;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_UP_TABLE:   up_table = data;
				REG_DOWN_TABLE: down_table = data;
				REG_ZERO_TABLE: zero_table = data[ZERO_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_command(logic [OP_W-1:0] op_v, logic [COORD_W-1:0] r_v,
				logic [COORD_W-1:0] c_v, logic s_v, logic [DRAW_W-1:0] draw_v);
			flip_result_t      want;
			int                r, c, idx, own, nsum, local_v;
			logic [DRAW_W-1:0] thresh;
			bit                take;

			want = '0;
			r = int'(r_v);
			c = int'(c_v);
			commands_noted++;
			if (r < LATTICE_SIDE && c < LATTICE_SIDE) begin
				idx = r * LATTICE_SIDE + c;
				own = spin_value(idx);
				nsum = 0;
				if (r > 0) nsum += spin_value(idx - LATTICE_SIDE);
				if (r < LATTICE_SIDE - 1) nsum += spin_value(idx + LATTICE_SIDE);
				if (c > 0) nsum += spin_value(idx - 1);
				if (c < LATTICE_SIDE - 1) nsum += spin_value(idx + 1);
				local_v = own * nsum;

				if (op_v == OP_LOAD) begin
					spin_total += (s_v ? 1 : -1) - own;
					lattice[idx] = s_v;
				end else if (op_v == OP_FLIP) begin
					// energy drops: flip regardless of the draw
					if (local_v < 0) begin
						take = 1'b1;
					end else begin
						if (local_v == 0)
							thresh = (own > 0) ? zero_table[15:0] : zero_table[31:16];
						else if (own > 0)
							thresh = up_table[(local_v - 1) * 16 +: 16];
						else
							thresh = down_table[(local_v - 1) * 16 +: 16];
						take = (thresh == THRESH_ALWAYS) || (draw_v < thresh);
					end
					if (take) begin
						lattice[idx] = !lattice[idx];
						spin_total -= 2 * own;
						want.flipped = 1'b1;
						flips_predicted++;
					end
				end
				want.spin    = lattice[idx];
				want.local_f = local_v[LOCAL_W-1:0];
			end
			want.mag = spin_total[MAG_W-1:0];
			pending_results.push_back(want);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t ns  mismatch: %s", $time, msg);
		endtask

		task check_result(logic spin, logic flip, logic signed [LOCAL_W-1:0] lf,
				logic signed [MAG_W-1:0] mag);
			flip_result_t want;

			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing expected", results_checked));
				return;
			end
			want = pending_results.pop_front();
			if (spin !== want.spin)
				report_mismatch($sformatf("beat %0d spin_out %b, want %b",
					results_checked, spin, want.spin));
			if (flip !== want.flipped)
				report_mismatch($sformatf("beat %0d flipped %b, want %b",
					results_checked, flip, want.flipped));
			if (lf !== want.local_f)
				report_mismatch($sformatf("beat %0d local_field %0d, want %0d",
					results_checked, lf, want.local_f));
			if (mag !== want.mag)
				report_mismatch($sformatf("beat %0d magnetization %0d, want %0d",
					results_checked, mag, want.mag));
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [OP_W-1:0]            op = OP_READ;
	logic [COORD_W-1:0]         row = '0;
	logic [COORD_W-1:0]         col = '0;
	logic                       spin_in = 1'b0;
	logic [DRAW_W-1:0]          random_draw = '0;
	logic                       done;
	logic                       spin_out;
	logic                       flipped;
	logic signed [LOCAL_W-1:0]  local_field;
	logic signed [MAG_W-1:0]    magnetization;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_UP_TABLE;
	logic [CFG_W-1:0]           cfg_data = '0;

	lattice_scoreboard  lattice_check;
	int                 idle_pct;
	int                 quiet_cycles = 0;
	int                 tables_programmed = 0;

	ising_metropolis_flip #(
		.SIDE(LATTICE_SIDE)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.row           (row),
		.col           (col),
		.spin_in       (spin_in),
		.random_draw   (random_draw),
		.done          (done),
		.spin_out      (spin_out),
		.flipped       (flipped),
		.local_field   (local_field),
		.magnetization (magnetization),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// Check every result beat at the edge that ends its cycle; the receiver has
	// no way to stall, so each beat is taken exactly once. Also feed the watchdog:
	// any accepted command or result beat counts as progress.
	always @(posedge clk) begin
		if (arst_n && done)
			lattice_check.check_result(spin_out, flipped, local_field, magnetization);
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one command and hold it until the block takes it. Call at a rising
	// edge; returns at the edge that accepted the beat. An optional idle gap comes
	// first, so gaps land at every point of the block's busy window.
	task automatic send_command(input logic [OP_W-1:0] op_v, input logic [COORD_W-1:0] r_v,
			input logic [COORD_W-1:0] c_v, input logic s_v, input logic [DRAW_W-1:0] d_v);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start       <= 1'b1;
		op          <= op_v;
		row         <= r_v;
		col         <= c_v;
		spin_in     <= s_v;
		random_draw <= d_v;
		do @(posedge clk); while (busy);
		lattice_check.note_command(op_v, r_v, c_v, s_v, d_v);
	endtask

	// Drop start and wait out every expected beat before touching the tables.
	task automatic drain();
		start <= 1'b0;
		while (lattice_check.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		lattice_check.set_register(idx, data);
	endtask

	// Write all three tables back to back. Junk goes in the unused upper half of
	// the zero-table write; the block must ignore it.
	task automatic program_tables(input logic [CFG_W-1:0] up_v, input logic [CFG_W-1:0] down_v,
			input logic [ZERO_W-1:0] zero_v);
		logic [31:0] junk;

		junk = $urandom;
		write_register(REG_UP_TABLE, up_v);
		write_register(REG_DOWN_TABLE, down_v);
		write_register(REG_ZERO_TABLE, {junk, zero_v});
		cfg_we <= 1'b0;
		tables_programmed++;
	endtask

	function automatic int pick_window_base();
		case ($urandom_range(3))
			0: return 0;
			1: return LATTICE_SIDE - WINDOW;
			default: return $urandom_range(LATTICE_SIDE - WINDOW);
		endcase
	endfunction

	// Mostly flips and loads inside a small patch so that neighbourhoods fill
	// with mixed spins; a tenth of the sites are anywhere in the lattice.
	task automatic send_random_command(input int base_r, input int base_c);
		logic [OP_W-1:0]    op_v;
		logic [COORD_W-1:0] r_v, c_v;
		logic [DRAW_W-1:0]  d_v;
		logic [CFG_W-1:0]   table_v;
		int                 pick;

		pick = $urandom_range(99);
		if (pick < 45)
			op_v = OP_FLIP;
		else if (pick < 75)
			op_v = OP_LOAD;
		else if (pick < 95)
			op_v = OP_READ;
		else
			op_v = OP_UNUSED;

		if ($urandom_range(9) == 0) begin
			r_v = COORD_W'($urandom);
			c_v = COORD_W'($urandom);
		end else begin
			r_v = COORD_W'(base_r + $urandom_range(WINDOW - 1));
			c_v = COORD_W'(base_c + $urandom_range(WINDOW - 1));
		end

		case ($urandom_range(7))
			0: d_v = '0;
			1: d_v = '1;
			2: begin
				// land on or next to a threshold
				table_v = $urandom_range(1) ? lattice_check.up_table : lattice_check.down_table;
				d_v = DRAW_W'(table_v[16 * $urandom_range(3) +: 16] + $urandom_range(2) - 1);
			end
			default: d_v = DRAW_W'($urandom);
		endcase

		send_command(op_v, r_v, c_v, 1'($urandom_range(1)), d_v);
	endtask

	initial begin
		int base_r, base_c;

		lattice_check = new();
		idle_pct = 27;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats with the tables as reset leaves them.
		send_command(OP_READ, 7'd0, 7'd0, 1'b0, '0);          // corner, two down neighbours
		send_command(OP_UNUSED, 7'd127, 7'd127, 1'b1, '1);    // unused op reads only
		send_command(OP_FLIP, 7'd0, 7'd127, 1'b1, '0);        // local +2, threshold 0: hold
		send_command(OP_READ, 7'd127, 7'd0, 1'b1, '1);
		send_command(OP_LOAD, 7'd1, 7'd1, 1'b1, '0);
		send_command(OP_LOAD, 7'd0, 7'd1, 1'b1, '1);
		send_command(OP_LOAD, 7'd2, 7'd1, 1'b1, '0);
		send_command(OP_LOAD, 7'd1, 7'd0, 1'b1, '0);
		send_command(OP_LOAD, 7'd1, 7'd2, 1'b1, '0);
		send_command(OP_FLIP, 7'd1, 7'd1, 1'b0, '0);          // up among four up, table 0: hold
		send_command(OP_FLIP, 7'd2, 7'd2, 1'b0, '1);          // local 0, always-accept code

		// Distinct code in every lane: always, never, half, minimum.
		drain();
		program_tables({16'hFFFF, 16'h0000, 16'h8000, 16'h0001},
			{16'h0001, 16'h0000, 16'h8000, 16'hFFFF}, 32'h0000_FFFF);
		send_command(OP_FLIP, 7'd1, 7'd1, 1'b0, '1);          // local 4 up, code FFFF: flip
		send_command(OP_FLIP, 7'd1, 7'd1, 1'b0, '1);          // negative local: always flips
		send_command(OP_FLIP, 7'd0, 7'd0, 1'b0, '0);          // negative local at a corner
		send_command(OP_FLIP, 7'd0, 7'd0, 1'b0, 16'h8000);    // draw equals threshold: hold
		send_command(OP_FLIP, 7'd0, 7'd0, 1'b0, 16'h7FFF);    // draw just below: flip
		send_command(OP_FLIP, 7'd3, 7'd3, 1'b0, '0);          // down, local 4, threshold 1
		send_command(OP_FLIP, 7'd2, 7'd2, 1'b1, '0);          // up, local 0, always code
		send_command(OP_LOAD, 7'd127, 7'd127, 1'b1, '0);
		send_command(OP_LOAD, 7'd127, 7'd127, 1'b1, '1);      // reload same spin
		send_command(OP_FLIP, 7'd127, 7'd126, 1'b0, '0);      // edge site beside an up spin

		// Random phases: sender idles 27, then 80, then 0 percent of the time.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_pct = (ph < 2) ? 27 : (ph < 4) ? 80 : 0;
			drain();
			case (ph)
				1: program_tables('1, '1, '0);
				2: program_tables('0, '0, '1);
				4: program_tables('1, {$urandom, $urandom}, {$urandom});
				default: program_tables({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % PATCH_ITEMS == 0) begin
					base_r = pick_window_base();
					base_c = pick_window_base();
				end
				send_random_command(base_r, base_c);
			end
		end

		drain();
		$display("run covered %0d commands and %0d result beats, %0d of them flips",
			lattice_check.commands_noted, lattice_check.results_checked,
			lattice_check.flips_predicted);
		$display("threshold tables programmed %0d times; sender idle 27, 80 and 0 percent",
			tables_programmed);
		if (lattice_check.mismatches == 0 && lattice_check.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/imf_pkg.sv
hw/rtl/ising_metropolis_flip.sv
test/ising_metropolis_flip_tb.sv
